[rtl/core/wildcard_pattern_matcher_unit_defines.svh]
// Assertion helpers for the wildcard pattern matcher.
// Each expects clk_i and rst_ni in the scope of use.
`ifndef WILDCARD_PATTERN_MATCHER_UNIT_DEFINES_SVH
`define WILDCARD_PATTERN_MATCHER_UNIT_DEFINES_SVH

// Invariant that holds at every clock edge out of reset.
`define WPM_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Same-cycle implication.
`define WPM_ASSERT_IMP(label, trig, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WPM_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/wpm_pkg.sv]
`default_nettype none

package wpm_pkg;

  localparam int MAX_PATTERN  = 32;
  localparam int SEP_SLOTS    = 4;
  localparam int POS_W        = MAX_PATTERN + 1;
  localparam int LEN_W        = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W        = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int CLOSE_LEVELS = $clog2(POS_W);
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;
  localparam int SEP_W        = 8 * SEP_SLOTS;

  localparam logic [7:0]       WILD_ONE  = 8'h3F;  // '?'
  localparam logic [7:0]       WILD_RUN  = 8'h2A;  // '*'
  localparam logic [7:0]       CHAR_A_UC = 8'h41;  // 'A'
  localparam logic [7:0]       CHAR_Z_UC = 8'h5A;  // 'Z'
  localparam logic [7:0]       FOLD_OFS  = 8'h20;
  localparam logic [SEP_W-1:0] SEP_RESET = SEP_W'(32'h003A5C2F);  // '/', '\', ':'

  localparam logic [POS_W-1:0] RESTART = POS_W'(1);

  typedef enum logic [1:0] {
    KIND_CLEAR   = 2'd0,
    KIND_PATTERN = 2'd1,
    KIND_TEXT    = 2'd2,
    KIND_END     = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CASE_FOLD      = 2'd0,
    CFG_STAR_NEEDS_ONE = 2'd1,
    CFG_SEPARATOR_SET  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic             case_fold;
    logic             star_needs_one;
    logic [SEP_W-1:0] separator_set;
  } cfg_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] byte_value;
  } item_t;

  function automatic logic [7:0] fold_byte(logic [7:0] c, logic fold);
    logic [7:0] r;
    r = c;
    if (fold && (c >= CHAR_A_UC) && (c <= CHAR_Z_UC)) begin
      r = c + FOLD_OFS;
    end
    return r;
  endfunction

  function automatic logic is_separator(logic [7:0] c, logic [SEP_W-1:0] set);
    logic hit;
    hit = 1'b0;
    for (int s = 0; s < SEP_SLOTS; s++) begin
      if ((set[8*s +: 8] != 8'h00) && (set[8*s +: 8] == c)) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

[rtl/core/wpm_if.sv]
`default_nettype none

// Input channel: one pattern/text/control transaction.
interface wpm_in_if;
  logic            valid;
  logic            ready;
  wpm_pkg::kind_e  kind;
  logic [7:0]      byte_value;

  modport source (output valid, output kind, output byte_value, input ready);
  modport sink   (input valid, input kind, input byte_value, output ready);
endinterface

// Result channel: one match verdict per end of text.
interface wpm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_overflow;

  modport source (output valid, output matched, output pattern_overflow, input ready);
  modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

`default_nettype wire

[rtl/core/wpm_star_close.sv]
`default_nettype none

// Zero-width star closure as a parallel prefix:
// closed[k] = active[k] | (closed[k-1] & star[k-1]).
module wpm_star_close (
  input  logic [wpm_pkg::POS_W-1:0]       active_i,
  input  logic [wpm_pkg::MAX_PATTERN-1:0] star_i,
  output logic [wpm_pkg::POS_W-1:0]       closed_o
);
  import wpm_pkg::*;

  always_comb begin
    logic [POS_W-1:0] g;
    logic [POS_W-1:0] p;
    logic [POS_W-1:0] g_sh;
    logic [POS_W-1:0] p_sh;
    g = active_i;
    p = {star_i, 1'b0};
    for (int l = 0; l < CLOSE_LEVELS; l++) begin
      g_sh = g << (1 << l);
      p_sh = p << (1 << l);
      g    = g | (p & g_sh);
      p    = p & p_sh;
    end
    closed_o = g;
  end

endmodule

`default_nettype wire

[rtl/core/wpm_engine.sv]
`default_nettype none

`include "wildcard_pattern_matcher_unit_defines.svh"

module wpm_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_valid_i,
  input  wpm_pkg::item_t item_i,
  output logic           item_take_o,
  input  wpm_pkg::cfg_t  cfg_i,
  wpm_out_if.source      out_o
);
  import wpm_pkg::*;

  logic [7:0]             store_q [MAX_PATTERN];
  logic [LEN_W-1:0]       len_q, len_d;
  logic [POS_W-1:0]       active_q, active_d;
  logic                   ovf_q, ovf_d;
  logic [POS_W-1:0]       closed;
  logic [POS_W-1:0]       step_vec;
  logic [POS_W-1:0]       beyond_len;
  logic [MAX_PATTERN-1:0] in_use;
  logic [MAX_PATTERN-1:0] star_free;
  logic                   sep;
  logic                   byte_nz;
  logic                   out_free;
  logic                   store_we;
  logic [IDX_W-1:0]       store_idx;
  logic                   out_valid_q, out_valid_d;
  logic                   res_load;
  logic                   res_matched_q, res_matched_d;
  logic                   res_ovf_q, res_ovf_d;

  // Position masks against the current length.
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      in_use[i]    = LEN_W'(i) < len_q;
      star_free[i] = in_use[i] && (store_q[i] == WILD_RUN) && !cfg_i.star_needs_one;
    end
    for (int k = 0; k < POS_W; k++) begin
      beyond_len[k] = LEN_W'(k) > len_q;
    end
  end

  wpm_star_close u_close (
    .active_i (active_q),
    .star_i   (star_free),
    .closed_o (closed)
  );

  // One text byte against every active position.
  always_comb begin
    logic [7:0] c_f;
    step_vec = '0;
    sep      = is_separator(item_i.byte_value, cfg_i.separator_set);
    c_f      = fold_byte(item_i.byte_value, cfg_i.case_fold);
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (closed[i] && in_use[i]) begin
        if (store_q[i] == WILD_ONE) begin
          if (!sep) step_vec[i+1] = 1'b1;
        end else if (store_q[i] == WILD_RUN) begin
          if (!sep) begin
            step_vec[i]   = 1'b1;
            step_vec[i+1] = 1'b1;
          end
        end else if (fold_byte(store_q[i], cfg_i.case_fold) == c_f) begin
          step_vec[i+1] = 1'b1;
        end
      end
    end
  end

  assign out_free    = !out_valid_q || out_o.ready;
  assign item_take_o = item_valid_i && ((item_i.kind != KIND_END) || out_free);
  assign byte_nz     = item_i.byte_value != 8'h00;

  always_comb begin
    len_d         = len_q;
    ovf_d         = ovf_q;
    active_d      = active_q;
    store_we      = 1'b0;
    store_idx     = len_q[IDX_W-1:0];
    out_valid_d   = out_valid_q && !out_o.ready;
    res_load      = 1'b0;
    res_matched_d = res_matched_q;
    res_ovf_d     = res_ovf_q;
    if (item_take_o) begin
      unique case (item_i.kind)
        KIND_CLEAR: begin
          len_d    = '0;
          ovf_d    = 1'b0;
          active_d = RESTART;
        end
        KIND_PATTERN: begin
          if (byte_nz) begin
            if (len_q < LEN_W'(MAX_PATTERN)) begin
              store_we = 1'b1;
              len_d    = len_q + LEN_W'(1);
            end else begin
              ovf_d = 1'b1;
            end
            active_d = RESTART;
          end
        end
        KIND_TEXT: begin
          if (byte_nz) active_d = step_vec;
        end
        KIND_END: begin
          out_valid_d   = 1'b1;
          res_load      = 1'b1;
          res_matched_d = closed[len_q] && !ovf_q;
          res_ovf_d     = ovf_q;
          active_d      = RESTART;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      ovf_q       <= 1'b0;
      active_q    <= RESTART;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      ovf_q       <= ovf_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Pattern bytes and result payload: no reset.
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[store_idx] <= item_i.byte_value;
    end
    if (res_load) begin
      res_matched_q <= res_matched_d;
      res_ovf_q     <= res_ovf_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.matched          = res_matched_q;
  assign out_o.pattern_overflow = res_ovf_q;

  `WPM_ASSERT_ALWAYS(a_len_bound, len_q <= LEN_W'(MAX_PATTERN), "pattern length past store")
  `WPM_ASSERT_ALWAYS(a_active_in_range, (active_q & beyond_len) == '0, "active past pattern end")
  `WPM_ASSERT_IMP(a_ovf_no_match, out_o.valid && out_o.pattern_overflow, !out_o.matched, "match on overflow")
  `WPM_ASSERT_NEXT(a_end_restarts, item_take_o && (item_i.kind == KIND_END), active_q == RESTART, "text not restarted")

endmodule

`default_nettype wire

[rtl/core/wildcard_pattern_matcher_unit.sv]
// Channel  | Dir | Payload                      | Transaction
// ---------+-----+------------------------------+-------------------------------
// in_i     | in  | kind, byte_value             | valid & ready at rising edge
// out_o    | out | matched, pattern_overflow    | valid & ready at rising edge
// cfg      | in  | cfg_index_i, cfg_data_i      | cfg_we_i at rising edge
//
// One transaction a cycle but for the stall below: an item is held in the input
// register and is folded into the position vector by combinational logic (star
// closure prefix, per-position compare) when the engine takes it; an end of text
// puts its verdict in the output register at that edge. A waiting verdict holds a
// following end of text in the input register, which stalls the input until the verdict is taken.
// Reset (rst_ni low, asynchronous): empty pattern, no overflow, only position
// zero active, registers at their reset values. Pattern bytes are not cleared.
`default_nettype none

module wildcard_pattern_matcher_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [wpm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wpm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  wpm_in_if.sink                         in_i,
  wpm_out_if.source                      out_o
);
  import wpm_pkg::*;

  cfg_t  cfg_q;
  logic  item_valid_q, item_valid_d;
  item_t item_q;
  logic  item_take;
  logic  in_accept;

  // Config writes; an unused index is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.case_fold      <= 1'b0;
      cfg_q.star_needs_one <= 1'b0;
      cfg_q.separator_set  <= SEP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_CASE_FOLD:      cfg_q.case_fold      <= cfg_data_i[0];
        CFG_STAR_NEEDS_ONE: cfg_q.star_needs_one <= cfg_data_i[0];
        CFG_SEPARATOR_SET:  cfg_q.separator_set  <= cfg_data_i[SEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register: loaded when empty or when the held item moves on.
  assign in_i.ready   = !item_valid_q || item_take;
  assign in_accept    = in_i.valid && in_i.ready;
  assign item_valid_d = in_accept || (item_valid_q && !item_take);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.kind       <= in_i.kind;
      item_q.byte_value <= in_i.byte_value;
    end
  end

  wpm_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid_q),
    .item_i       (item_q),
    .item_take_o  (item_take),
    .cfg_i        (cfg_q),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire
